// ===== hdl/mbd_pkg.sv =====
// ---------------------------------------------------------------------------
// mbd_pkg
// Shared types and constants for the mirrored box downsampler.
// ---------------------------------------------------------------------------
package mbd_pkg;

   // Default geometry, handed to the top level parameters
   localparam int FACE_COLS_DEF = 16;
   localparam int FACE_ROWS_DEF = 16;
   localparam int CELL_W_DEF    = 8;
   localparam int CELL_H_DEF    = 8;

   // Fixed field widths
   localparam int CH_W   = 8;   // one color channel
   localparam int PIX_W  = 10;  // blue + green + red
   localparam int SUM_W  = 18;  // cell accumulator
   localparam int IDX_W  = 6;   // face column / face row
   localparam int POS_W  = 11;  // frame column / row counter
   localparam int FW_W   = 12;  // frame_width register
   localparam int GRAY_W = 8;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH = 2'd0,
      CSR_WINDOW_LEFT = 2'd1,
      CSR_WINDOW_TOP  = 2'd2
   } csr_idx_type;

   localparam logic [FW_W-1:0]  FRAME_WIDTH_RST = 12'd640;
   localparam logic [POS_W-1:0] WINDOW_LEFT_RST = 11'd0;
   localparam logic [POS_W-1:0] WINDOW_TOP_RST  = 11'd0;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOCATE,
      ST_READ,
      ST_WRITE,
      ST_EMIT_READ,
      ST_EMIT_DIV,
      ST_EMIT_OUT
   } state_type;

   // Where the current pixel lands, from the locator to the sequencer
   typedef struct packed {
      logic             in_cell;  // pixel lies inside the face window
      logic [IDX_W-1:0] cell_col; // cell column of the pixel
      logic [IDX_W-1:0] band;     // band (cell row) of the pixel
      logic             emit;     // pixel closes a band of cells
      logic [PIX_W-1:0] pix;      // blue + green + red
   } loc_type;

endpackage

// ===== hdl/mbd_sum_mem.sv =====
// ---------------------------------------------------------------------------
// mbd_sum_mem
// Cell accumulator memory: one write port, one registered read port, and a
// valid bit per entry so that a cleared entry reads as zero.
// ---------------------------------------------------------------------------
module mbd_sum_mem
   import mbd_pkg::*;
#(
   parameter int DEPTH = FACE_COLS_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [SUM_W-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [SUM_W-1:0] wr_data
);

   logic [SUM_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic [SUM_W-1:0] rd_word_ff;
   logic             rd_valid_ff;

   always_comb begin
      valid_in = clear ? '0 : valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // Never-written entries read as zero
   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

// ===== hdl/mbd_locate.sv =====
// ---------------------------------------------------------------------------
// mbd_locate
// Frame position counters and window placement: finds the cell column and
// band of each pixel over two registered steps.
// ---------------------------------------------------------------------------
module mbd_locate
   import mbd_pkg::*;
#(
   parameter int FACE_COLS = FACE_COLS_DEF,
   parameter int FACE_ROWS = FACE_ROWS_DEF,
   parameter int CELL_W    = CELL_W_DEF,
   parameter int CELL_H    = CELL_H_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [CH_W-1:0]  blue,
   input  logic [CH_W-1:0]  green,
   input  logic [CH_W-1:0]  red,
   input  logic             frame_start,
   input  logic [FW_W-1:0]  frame_width,
   input  logic [POS_W-1:0] window_left,
   input  logic [POS_W-1:0] window_top,
   output loc_type          loc
);

   localparam int COL_SPAN = FACE_COLS * CELL_W;
   localparam int ROW_SPAN = FACE_ROWS * CELL_H;
   localparam int CDW = $clog2(COL_SPAN + 1);
   localparam int RDW = $clog2(ROW_SPAN + 1);
   // Reciprocal scaling: exact floor for every difference in range
   localparam int CS = CDW + 4;
   localparam int RS = RDW + 5;
   localparam int unsigned MC = ((1 << CS) + CELL_W - 1) / CELL_W;
   localparam int unsigned MR = ((1 << RS) + CELL_H - 1) / CELL_H;
   localparam logic [CS:0] MC_V = (CS+1)'(MC);
   localparam logic [RS:0] MR_V = (RS+1)'(MR);
   localparam logic [FW_W-1:0] COL_SPAN_V = FW_W'(COL_SPAN);
   localparam logic [FW_W-1:0] ROW_SPAN_V = FW_W'(ROW_SPAN);
   localparam logic [FW_W-1:0] MAX_WIDTH  = FW_W'(2048);

   logic [POS_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in;
   logic [POS_W-1:0] c_cur, y_cur, last_col;
   logic [FW_W-1:0]  dc_full, dy_full;
   logic             in_col, in_rows, row_end;

   logic [CDW-1:0]   s1_dc_ff;
   logic [RDW-1:0]   s1_dy_ff;
   logic             s1_in_col_ff, s1_in_rows_ff, s1_row_end_ff;
   logic [PIX_W-1:0] s1_pix_ff;

   logic [CDW+CS:0]  prod_c;
   logic [RDW+RS:0]  prod_r;
   logic [RDW+RS+1:0] prod_r1;
   logic [RDW:0]     dy_next;
   logic [IDX_W:0]   qy, qy1;
   loc_type          loc_ff, loc_in;

   // Position of this pixel; a frame start puts it at the origin
   always_comb begin
      c_cur = frame_start ? '0 : col_ff;
      y_cur = frame_start ? '0 : row_ff;
      if (frame_width == '0) begin
         last_col = '0;
      end else if (frame_width > MAX_WIDTH) begin
         last_col = POS_W'(MAX_WIDTH - 1'b1);
      end else begin
         last_col = POS_W'(frame_width - 1'b1);
      end
      dc_full = {1'b0, c_cur} - {1'b0, window_left};
      dy_full = {1'b0, y_cur} - {1'b0, window_top};
      in_col  = (c_cur >= window_left) && (dc_full < COL_SPAN_V);
      in_rows = (y_cur >= window_top) && (dy_full < ROW_SPAN_V);
      row_end = (c_cur >= last_col);
      if (row_end) begin
         col_in = '0;
         row_in = y_cur + 1'b1;
      end else begin
         col_in = c_cur + 1'b1;
         row_in = y_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_dc_ff      <= dc_full[CDW-1:0];
         s1_dy_ff      <= dy_full[RDW-1:0];
         s1_in_col_ff  <= in_col;
         s1_in_rows_ff <= in_rows;
         s1_row_end_ff <= row_end;
         s1_pix_ff     <= PIX_W'(blue) + PIX_W'(green) + PIX_W'(red);
      end
   end

   // Divide by the cell size through reciprocal multiplication; the band
   // closes where the quotient of (dy + 1) steps past that of dy
   always_comb begin
      dy_next = {1'b0, s1_dy_ff} + 1'b1;
      prod_c  = (CDW+CS+1)'(s1_dc_ff) * (CDW+CS+1)'(MC_V);
      prod_r  = (RDW+RS+1)'(s1_dy_ff) * (RDW+RS+1)'(MR_V);
      prod_r1 = (RDW+RS+2)'(dy_next) * (RDW+RS+2)'(MR_V);
      qy      = (IDX_W+1)'(prod_r >> RS);
      qy1     = (IDX_W+1)'(prod_r1 >> RS);
      loc_in.in_cell  = s1_in_col_ff && s1_in_rows_ff;
      loc_in.cell_col = IDX_W'(prod_c >> CS);
      loc_in.band     = qy[IDX_W-1:0];
      loc_in.emit     = s1_row_end_ff && s1_in_rows_ff && (qy1 != qy);
      loc_in.pix      = s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      loc_ff <= loc_in;
   end

   assign loc = loc_ff;

endmodule

// ===== hdl/mbd_gray.sv =====
// ---------------------------------------------------------------------------
// mbd_gray
// Cell average: floor(sum / (CELL_W*CELL_H*3)), saturated to 255, through a
// reciprocal multiply and one output register.
// ---------------------------------------------------------------------------
module mbd_gray
   import mbd_pkg::*;
#(
   parameter int CELL_W = CELL_W_DEF,
   parameter int CELL_H = CELL_H_DEF
) (
   input  logic              clock,
   input  logic              load,
   input  logic [SUM_W-1:0]  sum,
   output logic [GRAY_W-1:0] gray
);

   localparam int DIVISOR = CELL_W * CELL_H * 3;
   localparam int GS = SUM_W + 10;
   localparam int unsigned MG = ((1 << GS) + DIVISOR - 1) / DIVISOR;
   localparam logic [GS:0] MG_V = (GS+1)'(MG);
   localparam logic [SUM_W:0] LIMIT = (SUM_W+1)'(256 * DIVISOR);

   logic [SUM_W+GS:0]  prod;
   logic [GRAY_W-1:0]  gray_ff, gray_in;

   always_comb begin
      prod = (SUM_W+GS+1)'(sum) * (SUM_W+GS+1)'(MG_V);
      if ({1'b0, sum} >= LIMIT) begin
         gray_in = '1;
      end else begin
         gray_in = GRAY_W'(prod >> GS);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         gray_ff <= gray_in;
      end
   end

   assign gray = gray_ff;

endmodule

// ===== hdl/mirrored_box_downsampler.sv =====
// ---------------------------------------------------------------------------
// mirrored_box_downsampler
// Box-filters a BGR raster stream into a mirrored grid of gray face cells.
// ---------------------------------------------------------------------------
// Pixel flow: one pixel word in flight; the next is taken only after the
//   read-modify-write of the accumulator memory (locate, read, write back) and any band emission.
// Results: after the closing pixel is written back, each cell of the band
//   goes through read, divide and present, and the next cell starts once
//   the previous result is taken.
// Reset: counters clear, config returns to 640/0/0, accumulators read as
//   zero at once through per-entry valid bits (no clearing pass).
// ---------------------------------------------------------------------------
module mirrored_box_downsampler
   import mbd_pkg::*;
#(
   parameter int FACE_COLS = FACE_COLS_DEF,
   parameter int FACE_ROWS = FACE_ROWS_DEF,
   parameter int CELL_W    = CELL_W_DEF,
   parameter int CELL_H    = CELL_H_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel words
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CH_W-1:0]       req_blue,
   input  logic [CH_W-1:0]       req_green,
   input  logic [CH_W-1:0]       req_red,
   input  logic                  req_frame_start,
   // gray cell words
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [GRAY_W-1:0]     rsp_gray,
   output logic [IDX_W-1:0]      rsp_face_col,
   output logic [IDX_W-1:0]      rsp_face_row,
   output logic                  rsp_last,
   // configuration writes
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW = (FACE_COLS > 1) ? $clog2(FACE_COLS) : 1;
   localparam logic [AW-1:0]    LAST_CELL = AW'(FACE_COLS - 1);
   localparam logic [IDX_W-1:0] LAST_K    = IDX_W'(FACE_COLS - 1);

   // Configuration registers
   logic [FW_W-1:0]  frame_width_ff;
   logic [POS_W-1:0] window_left_ff;
   logic [POS_W-1:0] window_top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= FRAME_WIDTH_RST;
         window_left_ff <= WINDOW_LEFT_RST;
         window_top_ff  <= WINDOW_TOP_RST;
      end else if (csr_write) begin
         unique case (csr_idx_type'(csr_index))
            CSR_FRAME_WIDTH: frame_width_ff <= csr_data;
            CSR_WINDOW_LEFT: window_left_ff <= csr_data[POS_W-1:0];
            CSR_WINDOW_TOP:  window_top_ff  <= csr_data[POS_W-1:0];
            default: ;  // writes past the register list are dropped
         endcase
      end
   end

   // Sequencer state
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] k_ff, k_in;

   logic             accept;
   loc_type          loc;

   // Accumulator memory controls
   logic             mem_clear;
   logic             mem_rd_en;
   logic [AW-1:0]    mem_rd_addr;
   logic [SUM_W-1:0] mem_rd_data;
   logic             mem_wr_en;
   logic [SUM_W-1:0] mem_wr_data;
   logic             gray_load;

   assign accept = req_valid && req_ready;

   // Locate the pixel: counters, window test, cell and band
   mbd_locate #(
      .FACE_COLS (FACE_COLS),
      .FACE_ROWS (FACE_ROWS),
      .CELL_W    (CELL_W),
      .CELL_H    (CELL_H)
   ) u_locate (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .blue        (req_blue),
      .green       (req_green),
      .red         (req_red),
      .frame_start (req_frame_start),
      .frame_width (frame_width_ff),
      .window_left (window_left_ff),
      .window_top  (window_top_ff),
      .loc         (loc)
   );

   mbd_sum_mem #(
      .DEPTH (FACE_COLS),
      .AW    (AW)
   ) u_sum_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (mem_clear),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (loc.cell_col[AW-1:0]),
      .wr_data (mem_wr_data)
   );

   mbd_gray #(
      .CELL_W (CELL_W),
      .CELL_H (CELL_H)
   ) u_gray (
      .clock (clock),
      .load  (gray_load),
      .sum   (mem_rd_data),
      .gray  (rsp_gray)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   // One pixel at a time: locate, read the cell sum, add and write back.
   // A band-closing pixel then walks the cells right to left, one word each.
   always_comb begin
      state_in    = state_ff;
      k_in        = k_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      mem_clear   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = loc.cell_col[AW-1:0];
      mem_wr_en   = 1'b0;
      mem_wr_data = SUM_W'(mem_rd_data + SUM_W'(loc.pix));
      gray_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // a frame start drops any partly summed band
               mem_clear = req_frame_start;
               state_in  = ST_LOCATE;
            end
         end
         ST_LOCATE: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            mem_rd_en = loc.in_cell;
            state_in  = ST_WRITE;
         end
         ST_WRITE: begin
            mem_wr_en = loc.in_cell;
            k_in      = '0;
            state_in  = loc.emit ? ST_EMIT_READ : ST_IDLE;
         end
         ST_EMIT_READ: begin
            // result k belongs to the mirrored cell column
            mem_rd_en   = 1'b1;
            mem_rd_addr = LAST_CELL - k_ff[AW-1:0];
            state_in    = ST_EMIT_DIV;
         end
         ST_EMIT_DIV: begin
            gray_load = 1'b1;
            state_in  = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (k_ff == LAST_K) begin
                  // band delivered: clear every accumulator
                  mem_clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_EMIT_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_face_col = k_ff;
   assign rsp_face_row = loc.band;
   assign rsp_last     = (k_ff == LAST_K);

   // Input and output sides never hand off in the same cycle
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("pixel taken while a gray word is pending");

   // One pixel in flight: ready drops right after a pixel is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second pixel taken before write-back");

   // After the final cell of a band the block returns to taking pixels
   a_band_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> (req_ready && !rsp_valid))
      else $error("band emission did not end on the last cell");

   // Result index stays within the face grid
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (k_ff <= LAST_K))
      else $error("face column index out of range");

endmodule
